[design/hemisphere_ambient_shade_top_macros.svh]
// ============================================================================
// Hemisphere ambient shade assertion macros
// Shared property wrappers for the port checker.
// ============================================================================
`ifndef HEMISPHERE_AMBIENT_SHADE_TOP_MACROS_SVH
`define HEMISPHERE_AMBIENT_SHADE_TOP_MACROS_SVH

// Checks a property on every rising edge outside reset.
`define HAS_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("hemisphere shade port check failed");

// Checks that cons holds in the cycle after ante.
`define HAS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    `HAS_ASSERT(label, clk, rstn, (ante) |=> (cons))

`endif

[design/has_pkg.sv]
// ============================================================================
// Hemisphere ambient shade package
// Shared types and constants for the shading pipeline.
// ============================================================================
package has_pkg;

    localparam logic [15:0] ONE_Q15  = 16'd32768;
    localparam logic [15:0] HALF_Q15 = 16'd16384;
    localparam int DIV_CELLS  = 29;
    localparam int SQRT_CELLS = 15;

    localparam logic [2:0] REG_STRENGTH = 3'd0;
    localparam logic [2:0] REG_SKY_R    = 3'd1;
    localparam logic [2:0] REG_SKY_G    = 3'd2;
    localparam logic [2:0] REG_SKY_B    = 3'd3;
    localparam logic [2:0] REG_GND_R    = 3'd4;
    localparam logic [2:0] REG_GND_G    = 3'd5;
    localparam logic [2:0] REG_GND_B    = 3'd6;

    typedef struct packed {
        logic [2:0][15:0] amb;
        logic             yneg;
        logic             zero;
    } t_side;

    typedef struct packed {
        logic [15:0]      strength;
        logic [2:0][15:0] sky;
        logic [2:0][15:0] gnd;
    } t_cfg;

endpackage

[design/hemisphere_ambient_shade_top.sv]
// Throughput: one beat per cycle while the output is not stalled.
// 29 divider cells and 15 square root cells set the depth.
// Each stage holds its beat until the next one takes it, so bubbles close up under stall.
// Reset is synchronous and active low; it empties the pipeline and loads the register
// defaults (strength 0, all tints 1.0). No clearing pass is needed.
// ============================================================================
// Hemisphere ambient shade top level
// Normalises the normal, blends the tints and scales the ambient colour.
// ============================================================================
module hemisphere_ambient_shade_top
    import has_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // ambient_red, ambient_green, ambient_blue, normal_x, normal_y, normal_z
    input  logic [95:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // shaded_red, shaded_green, shaded_blue
    output logic [47:0] o_m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg cfg;

    has_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Stage A: squares.
    logic        r_a_v, a_rdy;
    logic [30:0] r_a_xx, r_a_yy, r_a_zz;
    t_side       r_a_side;
    logic [31:0] n_xx, n_yy, n_zz;
    t_side       n_a_side;

    // Stage B: sum of squares.
    logic        r_b_v, b_rdy;
    logic [31:0] r_b_s;
    logic [32:0] r_b_rem;
    t_side       r_b_side;

    assign n_xx = 32'($signed(i_s_axis_tdata[63:48]) * $signed(i_s_axis_tdata[63:48]));
    assign n_yy = 32'($signed(i_s_axis_tdata[79:64]) * $signed(i_s_axis_tdata[79:64]));
    assign n_zz = 32'($signed(i_s_axis_tdata[95:80]) * $signed(i_s_axis_tdata[95:80]));

    always_comb begin
        n_a_side.amb  = i_s_axis_tdata[47:0];
        n_a_side.yneg = i_s_axis_tdata[79];
        n_a_side.zero = (i_s_axis_tdata[95:48] == 48'd0);
    end

    assign a_rdy           = !r_a_v || b_rdy;
    assign o_s_axis_tready = a_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (a_rdy) begin
            r_a_v <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_rdy && i_s_axis_tvalid) begin
            r_a_xx   <= n_xx[30:0];
            r_a_yy   <= n_yy[30:0];
            r_a_zz   <= n_zz[30:0];
            r_a_side <= n_a_side;
        end
    end

    logic        div_v   [0:DIV_CELLS];
    logic        div_rdy [0:DIV_CELLS];
    logic [32:0] div_rem [0:DIV_CELLS];
    logic [31:0] div_den [0:DIV_CELLS];
    logic [28:0] div_quo [0:DIV_CELLS];
    t_side       div_side[0:DIV_CELLS];

    assign b_rdy = !r_b_v || div_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (b_rdy) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_rdy && r_a_v) begin
            r_b_s    <= 32'(r_a_xx) + 32'(r_a_yy) + 32'(r_a_zz);
            r_b_rem  <= 33'(r_a_yy);
            r_b_side <= r_a_side;
        end
    end

    assign div_v[0]    = r_b_v;
    assign div_rem[0]  = r_b_rem;
    assign div_den[0]  = r_b_s;
    assign div_quo[0]  = '0;
    assign div_side[0] = r_b_side;

    for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
        has_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (div_v[k]),
            .o_ready (div_rdy[k]),
            .i_rem   (div_rem[k]),
            .i_den   (div_den[k]),
            .i_quo   (div_quo[k]),
            .i_side  (div_side[k]),
            .o_valid (div_v[k+1]),
            .i_ready (div_rdy[k+1]),
            .o_rem   (div_rem[k+1]),
            .o_den   (div_den[k+1]),
            .o_quo   (div_quo[k+1]),
            .o_side  (div_side[k+1])
        );
    end

    logic        sq_v   [0:SQRT_CELLS];
    logic        sq_rdy [0:SQRT_CELLS];
    logic [29:0] sq_rad [0:SQRT_CELLS];
    logic [16:0] sq_rem [0:SQRT_CELLS];
    logic [14:0] sq_root[0:SQRT_CELLS];
    t_side       sq_side[0:SQRT_CELLS];

    assign sq_v[0]             = div_v[DIV_CELLS];
    assign div_rdy[DIV_CELLS]  = sq_rdy[0];
    assign sq_rad[0]           = {1'b0, div_quo[DIV_CELLS]};
    assign sq_rem[0]           = '0;
    assign sq_root[0]          = '0;
    assign sq_side[0]          = div_side[DIV_CELLS];

    for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
        has_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (sq_v[k]),
            .o_ready (sq_rdy[k]),
            .i_rad   (sq_rad[k]),
            .i_rem   (sq_rem[k]),
            .i_root  (sq_root[k]),
            .i_side  (sq_side[k]),
            .o_valid (sq_v[k+1]),
            .i_ready (sq_rdy[k+1]),
            .o_rad   (sq_rad[k+1]),
            .o_rem   (sq_rem[k+1]),
            .o_root  (sq_root[k+1]),
            .o_side  (sq_side[k+1])
        );
    end

    // Stage C: sky weight and tint products.
    logic             r_c_v, c_rdy;
    logic [2:0][31:0] r_c_pg, r_c_pk;
    logic [2:0][15:0] r_c_amb;
    logic [15:0]      n_w, n_wc;

    // Stage D: hemisphere tint.
    logic             r_d_v, d_rdy;
    logic [2:0][15:0] r_d_hemi, r_d_amb;
    logic [2:0][30:0] n_hsum;

    // Stage E: tint times strength.
    logic             r_e_v, e_rdy;
    logic [2:0][31:0] r_e_prod;
    logic [2:0][15:0] r_e_amb;
    logic [15:0]      n_st;

    // Stage F: effective tint.
    logic             r_f_v, f_rdy;
    logic [2:0][16:0] r_f_eff;
    logic [2:0][15:0] r_f_amb;
    logic [2:0][32:0] n_esum;

    // Stage G: ambient times tint.
    logic             r_g_v, g_rdy;
    logic [2:0][32:0] r_g_prod;

    // Stage H: rounding and saturation.
    logic             r_h_v, h_rdy;
    logic [2:0][15:0] r_h_out;
    logic [2:0][33:0] n_osum;

    assign sq_rdy[SQRT_CELLS] = c_rdy;

    always_comb begin
        if (sq_side[SQRT_CELLS].zero) begin
            n_w = ONE_Q15;
        end else if (sq_side[SQRT_CELLS].yneg) begin
            n_w = HALF_Q15 - {1'b0, sq_root[SQRT_CELLS]};
        end else begin
            n_w = HALF_Q15 + {1'b0, sq_root[SQRT_CELLS]};
        end
        n_wc = ONE_Q15 - n_w;
    end

    assign n_st = (cfg.strength > ONE_Q15) ? ONE_Q15 : cfg.strength;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_hsum[c] = 31'(r_c_pg[c]) + 31'(r_c_pk[c]) + 31'(HALF_Q15);
            n_esum[c] = {2'b00, ONE_Q15 - n_st, 15'd0} + 33'(r_e_prod[c]) + 33'(HALF_Q15);
            n_osum[c] = 34'(r_g_prod[c]) + 34'(HALF_Q15);
        end
    end

    assign c_rdy = !r_c_v || d_rdy;
    assign d_rdy = !r_d_v || e_rdy;
    assign e_rdy = !r_e_v || f_rdy;
    assign f_rdy = !r_f_v || g_rdy;
    assign g_rdy = !r_g_v || h_rdy;
    assign h_rdy = !r_h_v || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
            r_g_v <= 1'b0;
            r_h_v <= 1'b0;
        end else begin
            if (c_rdy) r_c_v <= sq_v[SQRT_CELLS];
            if (d_rdy) r_d_v <= r_c_v;
            if (e_rdy) r_e_v <= r_d_v;
            if (f_rdy) r_f_v <= r_e_v;
            if (g_rdy) r_g_v <= r_f_v;
            if (h_rdy) r_h_v <= r_g_v;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            if (c_rdy && sq_v[SQRT_CELLS]) begin
                r_c_pg[c]  <= cfg.gnd[c] * n_wc;
                r_c_pk[c]  <= cfg.sky[c] * n_w;
                r_c_amb[c] <= sq_side[SQRT_CELLS].amb[c];
            end
            if (d_rdy && r_c_v) begin
                r_d_hemi[c] <= n_hsum[c][30:15];
                r_d_amb[c]  <= r_c_amb[c];
            end
            if (e_rdy && r_d_v) begin
                r_e_prod[c] <= r_d_hemi[c] * n_st;
                r_e_amb[c]  <= r_d_amb[c];
            end
            if (f_rdy && r_e_v) begin
                r_f_eff[c] <= n_esum[c][31:15];
                r_f_amb[c] <= r_e_amb[c];
            end
            if (g_rdy && r_f_v) begin
                r_g_prod[c] <= 33'(r_f_amb[c]) * 33'(r_f_eff[c]);
            end
            if (h_rdy && r_g_v) begin
                r_h_out[c] <= (n_osum[c][33:31] != 3'd0) ? 16'hFFFF : n_osum[c][30:15];
            end
        end
    end

    assign o_m_axis_tvalid = r_h_v;
    assign o_m_axis_tdata  = r_h_out;

endmodule

[design/has_cfg.sv]
// ============================================================================
// Hemisphere ambient shade configuration registers
// APB register file holding the strength and the two tints.
// ============================================================================
module has_cfg
    import has_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    logic n_wr;

    assign pready = 1'b1;
    assign n_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.strength <= '0;
            r_cfg.sky      <= {3{ONE_Q15}};
            r_cfg.gnd      <= {3{ONE_Q15}};
        end else if (n_wr) begin
            case (paddr[4:2])
                REG_STRENGTH: r_cfg.strength <= pwdata[15:0];
                REG_SKY_R:    r_cfg.sky[0]   <= pwdata[15:0];
                REG_SKY_G:    r_cfg.sky[1]   <= pwdata[15:0];
                REG_SKY_B:    r_cfg.sky[2]   <= pwdata[15:0];
                REG_GND_R:    r_cfg.gnd[0]   <= pwdata[15:0];
                REG_GND_G:    r_cfg.gnd[1]   <= pwdata[15:0];
                REG_GND_B:    r_cfg.gnd[2]   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_STRENGTH: prdata = {16'd0, r_cfg.strength};
            REG_SKY_R:    prdata = {16'd0, r_cfg.sky[0]};
            REG_SKY_G:    prdata = {16'd0, r_cfg.sky[1]};
            REG_SKY_B:    prdata = {16'd0, r_cfg.sky[2]};
            REG_GND_R:    prdata = {16'd0, r_cfg.gnd[0]};
            REG_GND_G:    prdata = {16'd0, r_cfg.gnd[1]};
            REG_GND_B:    prdata = {16'd0, r_cfg.gnd[2]};
            default:      prdata = 32'd0;
        endcase
    end

endmodule

[design/has_div_cell.sv]
// ============================================================================
// Hemisphere ambient shade divider cell
// One restoring division step producing one quotient bit per beat.
// ============================================================================
module has_div_cell
    import has_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [32:0] i_rem,
    input  logic [31:0] i_den,
    input  logic [28:0] i_quo,
    input  t_side       i_side,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [32:0] o_rem,
    output logic [31:0] o_den,
    output logic [28:0] o_quo,
    output t_side       o_side
);

    logic        r_v;
    logic        n_ge;
    logic [32:0] n_diff;

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;
    assign n_ge    = i_rem >= {1'b0, i_den};
    assign n_diff  = n_ge ? (i_rem - {1'b0, i_den}) : i_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            o_rem  <= {n_diff[31:0], 1'b0};
            o_den  <= i_den;
            o_quo  <= {i_quo[27:0], n_ge};
            o_side <= i_side;
        end
    end

endmodule

[design/has_sqrt_cell.sv]
// ============================================================================
// Hemisphere ambient shade square root cell
// One digit-by-digit square root step producing one root bit per beat.
// ============================================================================
module has_sqrt_cell
    import has_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [29:0] i_rad,
    input  logic [16:0] i_rem,
    input  logic [14:0] i_root,
    input  t_side       i_side,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [29:0] o_rad,
    output logic [16:0] o_rem,
    output logic [14:0] o_root,
    output t_side       o_side
);

    logic        r_v;
    logic [18:0] n_cur;
    logic [18:0] n_trial;
    logic        n_ge;
    logic [18:0] n_diff;

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;
    assign n_cur   = {i_rem, i_rad[29:28]};
    assign n_trial = {2'b00, i_root, 2'b01};
    assign n_ge    = n_cur >= n_trial;
    assign n_diff  = n_ge ? (n_cur - n_trial) : n_cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            o_rad  <= {i_rad[27:0], 2'b00};
            o_rem  <= n_diff[16:0];
            o_root <= {i_root[13:0], n_ge};
            o_side <= i_side;
        end
    end

endmodule

[design/has_checker.sv]
// ============================================================================
// Hemisphere ambient shade port checker
// Watches the top-level ports and flags handshake and flow slips.
// ============================================================================
`include "hemisphere_ambient_shade_top_macros.svh"

module has_checker
    import has_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata,
    input logic        pready
);

    `HAS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata))
    `HAS_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !o_m_axis_tvalid |-> o_s_axis_tready)
    `HAS_ASSERT(a_ready_when_drained, i_clk, i_rst_n, i_m_axis_tready |-> o_s_axis_tready)
    `HAS_ASSERT(a_apb_ready, i_clk, i_rst_n, pready)

endmodule

bind hemisphere_ambient_shade_top has_checker u_has_checker (.*);

[tb/sv/hemisphere_ambient_shade_top_tb.sv]
// ============================================================================
// Hemisphere ambient shade testbench
// Drives shaded points through the stream input, and checks every output beat
// against a bit-exact shading predictor or, for 3 directed rows, fixed values.
// Register settings change between phases through the APB port. Both stream
// sides idle and stall at random; one long output stall fills the pipeline.
// ============================================================================
module hemisphere_ambient_shade_top_tb;
    import has_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] amb_b;
        logic [15:0] amb_g;
        logic [15:0] amb_r;
        logic [15:0] nz;
        logic [15:0] ny;
        logic [15:0] nx;
        logic        typed;
        logic [15:0] exp_r;
        logic [15:0] exp_g;
        logic [15:0] exp_b;
    } t_point_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [95:0] i_s_axis_tdata = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [47:0] o_m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic [15:0] shade_regs [0:6];
    logic [47:0] shaded_q [$];
    int          mismatches = 0;
    int          sent_points = 0;
    int          recv_beats = 0;
    bit          stimulus_done = 1'b0;

    localparam logic [2:0] REG_UNMAPPED = 3'd7;

    localparam int N_DIRECTED = 12;
    localparam t_point_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b1,
          16'hFFFF, 16'hFFFF, 16'hFFFF},
        '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 1'b1,
          16'h0000, 16'h0000, 16'h0000},
        '{16'h8000, 16'h4000, 16'h0001, 16'h0000, 16'h7FFF, 16'h0000, 1'b1,
          16'h0001, 16'h4000, 16'h8000},
        '{16'h1234, 16'hABCD, 16'hFFFF, 16'h7FFF, 16'h0000, 16'h0000, 1'b0, '0, '0, '0},
        '{16'hFFFF, 16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0, '0, '0, '0},
        '{16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, '0, '0, '0},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0001, 16'h0000, 1'b0, '0, '0, '0},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 1'b0, '0, '0, '0},
        '{16'h7FFF, 16'h0001, 16'hC000, 16'h0000, 16'h0000, 16'h8000, 1'b0, '0, '0, '0},
        '{16'h5555, 16'hAAAA, 16'h3333, 16'h2000, 16'hE000, 16'h1000, 1'b0, '0, '0, '0},
        '{16'hFFFF, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0, '0, '0},
        '{16'h0001, 16'hFFFE, 16'h7FFF, 16'hFFFF, 16'h4000, 16'h0001, 1'b0, '0, '0, '0}
    };

    hemisphere_ambient_shade_top uut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #500000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned sky_weight(logic signed [15:0] nx,
                                                   logic signed [15:0] ny,
                                                   logic signed [15:0] nz);
        longint signed x;
        longint signed y;
        longint signed z;
        longint unsigned len_sq;
        longint unsigned ay;
        longint unsigned mag;
        x = nx;
        y = ny;
        z = nz;
        len_sq = x * x + y * y + z * z;
        if (len_sq == 0) return ONE_Q15;
        ay = (y < 0) ? -y : y;
        mag = int_sqrt(((ay * ay) << 28) / len_sq);
        if (mag > HALF_Q15) mag = HALF_Q15;
        return (y < 0) ? HALF_Q15 - mag : HALF_Q15 + mag;
    endfunction

    function automatic logic [47:0] shade_point(t_point_row p);
        longint unsigned w;
        longint unsigned st;
        longint unsigned amb;
        longint unsigned hemi;
        longint unsigned eff;
        longint unsigned o;
        logic [47:0] res;
        w = sky_weight(p.nx, p.ny, p.nz);
        st = (shade_regs[REG_STRENGTH] > ONE_Q15) ? ONE_Q15 : shade_regs[REG_STRENGTH];
        for (int c = 0; c < 3; c++) begin
            amb = (c == 0) ? p.amb_r : (c == 1) ? p.amb_g : p.amb_b;
            hemi = (shade_regs[REG_GND_R + c] * (ONE_Q15 - w)
                    + shade_regs[REG_SKY_R + c] * w + HALF_Q15) >> 15;
            eff = (64'd32768 * (ONE_Q15 - st) + hemi * st + HALF_Q15) >> 15;
            o = (amb * eff + HALF_Q15) >> 15;
            if (o > 16'hFFFF) o = 16'hFFFF;
            res[c*16 +: 16] = o[15:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s at %0t: got %h, want %h", what, $realtime, got, want);
        mismatches++;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'h0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx <= REG_GND_B) shade_regs[idx] = value;
    endtask

    task automatic wait_idle();
        wait (shaded_q.size() == 0);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic send_point(t_point_row p);
        int gap;
        gap = ((sent_points / 64) % 4 == 0) ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {p.nz, p.ny, p.nx, p.amb_b, p.amb_g, p.amb_r};
        do @(posedge i_clk); while (!o_s_axis_tready);
        shaded_q.push_back(p.typed ? {p.exp_b, p.exp_g, p.exp_r} : shade_point(p));
        sent_points++;
    endtask

    function automatic logic [15:0] rand_normal_part();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 8) - 4);
            1: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic random_points(int count);
        t_point_row p;
        for (int i = 0; i < count; i++) begin
            p = '0;
            p.amb_r = $urandom_range(0, 7) == 0 ? 16'hFFFF : 16'($urandom_range(0, 65535));
            p.amb_g = 16'($urandom_range(0, 65535));
            p.amb_b = 16'($urandom_range(0, 65535));
            if ($urandom_range(0, 9) != 0) begin
                p.nx = rand_normal_part();
                p.ny = rand_normal_part();
                p.nz = rand_normal_part();
            end
            send_point(p);
        end
    endtask

    task automatic random_tints(logic [15:0] strength);
        write_reg(REG_STRENGTH, strength);
        for (int r = REG_SKY_R; r <= REG_GND_B; r++)
            write_reg(3'(r), 16'($urandom_range(0, 65535)));
    endtask

    initial begin
        t_point_row p;
        shade_regs[REG_STRENGTH] = 16'h0;
        for (int r = REG_SKY_R; r <= REG_GND_B; r++) shade_regs[r] = ONE_Q15;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) send_point(DIRECTED_ROWS[i]);
        i_s_axis_tvalid <= 1'b0;
        wait_idle();

        write_reg(REG_STRENGTH, ONE_Q15);
        for (int r = REG_SKY_R; r <= REG_SKY_B; r++) write_reg(3'(r), 16'hFFFF);
        for (int r = REG_GND_R; r <= REG_GND_B; r++) write_reg(3'(r), 16'h0000);
        for (int i = 0; i < N_DIRECTED; i++) begin
            p = DIRECTED_ROWS[i];
            p.typed = 1'b0;
            send_point(p);
        end
        random_points(200);
        i_s_axis_tvalid <= 1'b0;
        wait_idle();

        write_reg(REG_STRENGTH, 16'hFFFF);
        for (int r = REG_SKY_R; r <= REG_SKY_B; r++) write_reg(3'(r), 16'h0000);
        for (int r = REG_GND_R; r <= REG_GND_B; r++) write_reg(3'(r), 16'hFFFF);
        random_points(220);
        i_s_axis_tvalid <= 1'b0;
        wait_idle();

        random_tints(16'($urandom_range(0, 32768)));
        random_points(220);
        i_s_axis_tvalid <= 1'b0;
        wait_idle();

        random_tints(16'($urandom_range(0, 65535)));
        write_reg(REG_UNMAPPED, 16'($urandom_range(0, 65535)));
        random_points(220);
        i_s_axis_tvalid <= 1'b0;
        wait_idle();

        random_tints(16'($urandom_range(1, 4096)));
        random_points(220);
        i_s_axis_tvalid <= 1'b0;
        stimulus_done = 1'b1;
    end

    initial begin
        int stall;
        logic [47:0] want;
        wait (i_rst_n);
        forever begin
            stall = ((recv_beats / 150) % 3 == 0) ? 0 : $urandom_range(0, 11);
            if (recv_beats == 500) stall = 400;
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            recv_beats++;
            if (shaded_q.size() == 0) begin
                report_mismatch("unexpected beat", o_m_axis_tdata[15:0], 16'h0000);
            end else begin
                want = shaded_q.pop_front();
                if (o_m_axis_tdata[15:0] !== want[15:0])
                    report_mismatch("shaded_red", o_m_axis_tdata[15:0], want[15:0]);
                if (o_m_axis_tdata[31:16] !== want[31:16])
                    report_mismatch("shaded_green", o_m_axis_tdata[31:16], want[31:16]);
                if (o_m_axis_tdata[47:32] !== want[47:32])
                    report_mismatch("shaded_blue", o_m_axis_tdata[47:32], want[47:32]);
            end
        end
    end

    initial begin
        wait (stimulus_done);
        wait (shaded_q.size() == 0);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[hemisphere_ambient_shade_top.f]
+incdir+design
design/has_pkg.sv
design/has_cfg.sv
design/has_div_cell.sv
design/has_sqrt_cell.sv
design/hemisphere_ambient_shade_top.sv
design/has_checker.sv
tb/sv/hemisphere_ambient_shade_top_tb.sv
